[design/aid_pkg.sv]
// Shared types, register indexes and constants for the accelerometer impact detector.
package aid_pkg;

	// Configuration register indexes
	localparam logic [2:0] REG_BASE_X   = 3'd0;
	localparam logic [2:0] REG_BASE_Y   = 3'd1;
	localparam logic [2:0] REG_BASE_Z   = 3'd2;
	localparam logic [2:0] REG_IMPACT   = 3'd3;
	localparam logic [2:0] REG_SETTLE   = 3'd4;
	localparam logic [2:0] REG_LOCKOUT  = 3'd5;
	localparam logic [2:0] REG_HOLD     = 3'd6;

	localparam logic [15:0] IMPACT_LEVEL_RST = 16'd3500;
	localparam logic [15:0] SETTLE_LEVEL_RST = 16'd300;
	localparam logic [15:0] LOCKOUT_MS_RST   = 16'd300;
	localparam logic [15:0] HOLD_MS_RST      = 16'd1000;

	localparam logic [31:0] IMPACT_SQ_RST =
		32'(IMPACT_LEVEL_RST) * 32'(IMPACT_LEVEL_RST);
	localparam logic [31:0] SETTLE_SQ_RST =
		32'(SETTLE_LEVEL_RST) * 32'(SETTLE_LEVEL_RST);

	// Severity grades on the squared peak
	localparam logic [37:0] SEVERE_SQ   = 38'd49000000;
	localparam logic [37:0] MODERATE_SQ = 38'd25000000;

	localparam logic [1:0] SEV_MINOR    = 2'd0;
	localparam logic [1:0] SEV_MODERATE = 2'd1;
	localparam logic [1:0] SEV_SEVERE   = 2'd2;

	// Reported motion state codes
	localparam logic [1:0] MOTION_IDLE   = 2'd0;
	localparam logic [1:0] MOTION_IMPACT = 2'd1;
	localparam logic [1:0] MOTION_STABLE = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_IMPACT = 3'b010,
		ST_STABLE = 3'b100
	} mode_t;

	// Configuration as seen by the datapath; levels are kept squared
	typedef struct packed {
		logic signed [15:0] base_x;
		logic signed [15:0] base_y;
		logic signed [15:0] base_z;
		logic [31:0]        impact_sq;
		logic [31:0]        settle_sq;
		logic [15:0]        lockout_ms;
		logic [15:0]        hold_ms;
	} cfg_t;

endpackage

[design/aid_cfg.sv]
// Configuration register file; impact and settle levels are stored squared.
module aid_cfg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	output aid_pkg::cfg_t      cfg
);

	aid_pkg::cfg_t cfg_q;
	logic [31:0]   data_sq;

	assign cfg_ready = 1'b1;
	assign data_sq   = {16'b0, cfg_data} * {16'b0, cfg_data};
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_x     <= '0;
			cfg_q.base_y     <= '0;
			cfg_q.base_z     <= '0;
			cfg_q.impact_sq  <= aid_pkg::IMPACT_SQ_RST;
			cfg_q.settle_sq  <= aid_pkg::SETTLE_SQ_RST;
			cfg_q.lockout_ms <= aid_pkg::LOCKOUT_MS_RST;
			cfg_q.hold_ms    <= aid_pkg::HOLD_MS_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				aid_pkg::REG_BASE_X:  cfg_q.base_x     <= signed'(cfg_data);
				aid_pkg::REG_BASE_Y:  cfg_q.base_y     <= signed'(cfg_data);
				aid_pkg::REG_BASE_Z:  cfg_q.base_z     <= signed'(cfg_data);
				aid_pkg::REG_IMPACT:  cfg_q.impact_sq  <= data_sq;
				aid_pkg::REG_SETTLE:  cfg_q.settle_sq  <= data_sq;
				aid_pkg::REG_LOCKOUT: cfg_q.lockout_ms <= cfg_data;
				aid_pkg::REG_HOLD:    cfg_q.hold_ms    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

endmodule

[design/aid_change.sv]
// Baseline removal and squared magnitude of the change from the previous sample.
module aid_change (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic signed [15:0] accel_x,
	input  logic signed [15:0] accel_y,
	input  logic signed [15:0] accel_z,
	input  aid_pkg::cfg_t      cfg,
	output logic [37:0]        change_sq
);

	logic signed [16:0] off_x, off_y, off_z;
	logic signed [16:0] prev_x_q, prev_y_q, prev_z_q;
	logic signed [17:0] d_x, d_y, d_z;
	logic signed [35:0] sq_x, sq_y, sq_z;

	assign off_x = {accel_x[15], accel_x} - {cfg.base_x[15], cfg.base_x};
	assign off_y = {accel_y[15], accel_y} - {cfg.base_y[15], cfg.base_y};
	assign off_z = {accel_z[15], accel_z} - {cfg.base_z[15], cfg.base_z};

	assign d_x = {off_x[16], off_x} - {prev_x_q[16], prev_x_q};
	assign d_y = {off_y[16], off_y} - {prev_y_q[16], prev_y_q};
	assign d_z = {off_z[16], off_z} - {prev_z_q[16], prev_z_q};

	assign sq_x = d_x * d_x;
	assign sq_y = d_y * d_y;
	assign sq_z = d_z * d_z;

	// squares are never negative, so zero extension is exact
	assign change_sq = {2'b0, sq_x} + {2'b0, sq_y} + {2'b0, sq_z};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q <= '0;
			prev_y_q <= '0;
			prev_z_q <= '0;
		end else if (adv) begin
			prev_x_q <= off_x;
			prev_y_q <= off_y;
			prev_z_q <= off_z;
		end
	end

endmodule

[design/aid_fsm.sv]
// Idle/impact/stable state machine, peak tracking, severity and the result register.
module aid_fsm (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  logic [37:0]   csq,
	input  logic [31:0]   now_ms,
	input  aid_pkg::cfg_t cfg,
	output logic [1:0]    motion_state,
	output logic [37:0]   change_sq,
	output logic          new_impact,
	output logic          alert_pulse,
	output logic          report_valid,
	output logic [1:0]    severity,
	output logic [37:0]   peak_sq,
	output logic [15:0]   impact_total
);

	aid_pkg::mode_t mode_q, mode_d;
	logic [37:0]    peak_q, peak_d, peak_max, peak_out;
	logic [31:0]    impact_stamp_q, impact_stamp_d;
	logic [31:0]    stable_stamp_q, stable_stamp_d;
	logic [15:0]    count_q, count_d;
	logic           alert_sent_q, alert_sent_d;
	logic [31:0]    lock_el, hold_el;
	logic           over, do_start, started, report, pulse;
	logic [1:0]     sev, code;

	logic [1:0]     state_q, sev_q;
	logic [37:0]    csq_q, peak_out_q;
	logic           started_q, pulse_q, report_q;

	assign lock_el  = now_ms - impact_stamp_q;
	assign hold_el  = now_ms - stable_stamp_q;
	assign over     = csq > {6'b0, cfg.impact_sq};
	assign peak_max = (csq > peak_q) ? csq : peak_q;

	always_comb begin
		mode_d         = mode_q;
		peak_d         = peak_q;
		impact_stamp_d = impact_stamp_q;
		stable_stamp_d = stable_stamp_q;
		count_d        = count_q;
		alert_sent_d   = alert_sent_q;
		do_start       = 1'b0;
		started        = 1'b0;
		report         = 1'b0;
		pulse          = 1'b0;
		sev            = aid_pkg::SEV_MINOR;
		peak_out       = '0;
		unique case (mode_q)
			aid_pkg::ST_IMPACT: begin
				peak_d = peak_max;
				if (lock_el > {16'b0, cfg.lockout_ms} && csq < {6'b0, cfg.settle_sq}) begin
					mode_d         = aid_pkg::ST_STABLE;
					stable_stamp_d = now_ms;
					report         = 1'b1;
					peak_out       = peak_max;
					peak_d         = '0;
					if (peak_max > aid_pkg::SEVERE_SQ) begin
						sev = aid_pkg::SEV_SEVERE;
					end else if (peak_max > aid_pkg::MODERATE_SQ) begin
						sev = aid_pkg::SEV_MODERATE;
					end
				end
			end
			aid_pkg::ST_STABLE: begin
				if (over) begin
					do_start = 1'b1;
				end else if (hold_el > {16'b0, cfg.hold_ms}) begin
					mode_d = aid_pkg::ST_IDLE;
				end
			end
			default: begin
				// idle, and any unknown code behaves as idle
				if (over) begin
					do_start = 1'b1;
				end else begin
					mode_d = aid_pkg::ST_IDLE;
				end
			end
		endcase

		if (do_start) begin
			mode_d         = aid_pkg::ST_IMPACT;
			count_d        = count_q + 16'd1;
			impact_stamp_d = now_ms;
			peak_d         = csq;
			started        = 1'b1;
		end

		// one alert per excursion from idle
		if (mode_d == aid_pkg::ST_IMPACT && !alert_sent_q) begin
			pulse        = 1'b1;
			alert_sent_d = 1'b1;
		end else if (mode_d == aid_pkg::ST_IDLE) begin
			alert_sent_d = 1'b0;
		end

		unique case (mode_d)
			aid_pkg::ST_IMPACT: code = aid_pkg::MOTION_IMPACT;
			aid_pkg::ST_STABLE: code = aid_pkg::MOTION_STABLE;
			default:            code = aid_pkg::MOTION_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= aid_pkg::ST_IDLE;
			peak_q         <= '0;
			impact_stamp_q <= '0;
			stable_stamp_q <= '0;
			count_q        <= '0;
			alert_sent_q   <= 1'b0;
		end else if (adv) begin
			mode_q         <= mode_d;
			peak_q         <= peak_d;
			impact_stamp_q <= impact_stamp_d;
			stable_stamp_q <= stable_stamp_d;
			count_q        <= count_d;
			alert_sent_q   <= alert_sent_d;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			state_q    <= code;
			csq_q      <= csq;
			started_q  <= started;
			pulse_q    <= pulse;
			report_q   <= report;
			sev_q      <= sev;
			peak_out_q <= peak_out;
		end
	end

	assign motion_state = state_q;
	assign change_sq    = csq_q;
	assign new_impact   = started_q;
	assign alert_pulse  = pulse_q;
	assign report_valid = report_q;
	assign severity     = sev_q;
	assign peak_sq      = peak_out_q;
	assign impact_total = count_q;

endmodule

[design/accel_impact_detector.sv]
// An accepted sample is held in the input register, and its result then in the result register.
// Throughput: one sample per cycle while out_stall is low; input register, one pass of squaring and
// state logic, then the result register; the input register can take one more sample while a result waits.
// Reset (arst_n low, asynchronous): state idle, previous sample, peak, stamps, count cleared,
// registers to their defaults (levels 3500 and 300, lockout 300 ms, hold 1000 ms).
module accel_impact_detector (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] accel_x,
	input  logic signed [15:0] accel_y,
	input  logic signed [15:0] accel_z,
	input  logic [31:0]        now_ms,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         motion_state,
	output logic [37:0]        change_sq,
	output logic               new_impact,
	output logic               alert_pulse,
	output logic               report_valid,
	output logic [1:0]         severity,
	output logic [37:0]        peak_sq,
	output logic [15:0]        impact_total,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	aid_pkg::cfg_t      cfg;
	logic               s1_valid_q, out_valid_q;
	logic signed [15:0] ax_s1, ay_s1, az_s1;
	logic [31:0]        now_s1;
	logic               out_free, adv, accept;
	logic [37:0]        csq;

	assign out_free = !out_valid_q || !out_stall;
	assign adv      = s1_valid_q && out_free;
	assign in_stall = s1_valid_q && !out_free;
	assign accept   = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (adv) begin
				s1_valid_q <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ax_s1  <= accel_x;
			ay_s1  <= accel_y;
			az_s1  <= accel_z;
			now_s1 <= now_ms;
		end
	end

	aid_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	aid_change u_change (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.accel_x   (ax_s1),
		.accel_y   (ay_s1),
		.accel_z   (az_s1),
		.cfg       (cfg),
		.change_sq (csq)
	);

	aid_fsm u_fsm (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.csq          (csq),
		.now_ms       (now_s1),
		.cfg          (cfg),
		.motion_state (motion_state),
		.change_sq    (change_sq),
		.new_impact   (new_impact),
		.alert_pulse  (alert_pulse),
		.report_valid (report_valid),
		.severity     (severity),
		.peak_sq      (peak_sq),
		.impact_total (impact_total)
	);

`ifndef SYNTH
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled while the result register can drain");

	a_report_in_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && report_valid) |-> (motion_state == aid_pkg::MOTION_STABLE))
		else $error("report outside stable state");

	a_start_in_impact: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (new_impact || alert_pulse)) |->
			(motion_state == aid_pkg::MOTION_IMPACT))
		else $error("impact start or alert outside impact state");

	a_no_report_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !report_valid) |->
			(severity == aid_pkg::SEV_MINOR && peak_sq == '0))
		else $error("severity or peak set without a report");

	a_severe_grade: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && report_valid && severity == aid_pkg::SEV_SEVERE) |->
			(peak_sq > aid_pkg::SEVERE_SQ))
		else $error("severe grade on a small peak");
`endif

endmodule
